// ===== hdl/integer_literal_parser_128_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer literal parser
// Shared property forms. The enclosing module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef INTEGER_LITERAL_PARSER_128_MACROS_SVH
`define INTEGER_LITERAL_PARSER_128_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_literal_parser_128: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ILP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_literal_parser_128: next-cycle check failed");

`endif

// ===== hdl/ilp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ilp_pkg
// Types, character codes and the digit decoder of the integer literal parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

    localparam int TEXT_W  = 8;
    localparam int VALUE_W = 64;
    localparam int ACC_W   = 2 * VALUE_W;
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 6;

    localparam logic [TEXT_W-1:0] CHAR_NUL        = 8'h00;
    localparam logic [TEXT_W-1:0] CHAR_ZERO       = 8'h30;
    localparam logic [TEXT_W-1:0] CHAR_MINUS      = 8'h2D;
    localparam logic [TEXT_W-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [TEXT_W-1:0] CHAR_X          = 8'h78;
    localparam logic [TEXT_W-1:0] CHAR_D          = 8'h64;
    localparam logic [TEXT_W-1:0] CHAR_B          = 8'h62;

    localparam logic [RADIX_W-1:0] RADIX_2  = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_8  = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_10 = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_16 = 5'd16;

    // Not below any radix, so an invalid character other than the underscore always freezes the value.
    localparam logic [DIGIT_W-1:0] DIGIT_INVALID = 6'd63;

    typedef enum logic [1:0] {
        PH_START,
        PH_ZERO,
        PH_DIGITS,
        PH_FROZEN
    } ilp_phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_high;
        logic [VALUE_W-1:0] value_low;
    } ilp_result_t;

    typedef struct packed {
        ilp_phase_t phase;
        logic       negate;
    } ilp_status_t;

    function automatic logic [DIGIT_W-1:0] digit_value(input logic [TEXT_W-1:0] c);
        logic [DIGIT_W-1:0] dv;
        dv = DIGIT_INVALID;
        if (c inside {[8'h30:8'h39]})
        begin
            dv = DIGIT_W'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h5A]})
        begin
            dv = DIGIT_W'(c - 8'h41 + 8'd10);
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            dv = DIGIT_W'(c - 8'h61 + 8'd10);
        end
        return dv;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ilp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ilp_if
// Valid/ready channels for text bytes and parsed values.
// ----------------------------------------------------------------------------
interface ilp_text_if
    import ilp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TEXT_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface ilp_value_if
    import ilp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value_low;
    logic [VALUE_W-1:0] value_high;

    modport source (output valid, output value_low, output value_high, input ready);
    modport sink   (input valid, input value_low, input value_high, output ready);
endinterface
`default_nettype wire

// ===== hdl/ilp_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ilp_in_stage
// Input register that holds one text byte until the parser takes it.
// ----------------------------------------------------------------------------
module ilp_in_stage
    import ilp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    ilp_text_if.sink               text,
    input  wire logic              take,
    output      logic              byte_valid,
    output      logic [TEXT_W-1:0] byte_data
);

    logic              valid_reg;
    logic              valid_next;
    logic [TEXT_W-1:0] byte_reg;
    logic              load;

    assign text.ready = !valid_reg || take;
    assign load       = text.valid && text.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= text.text_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule
`default_nettype wire

// ===== hdl/ilp_parse_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ilp_parse_core
// Prefix and sign decoding, radix multiply-add and final negation.
// ----------------------------------------------------------------------------
module ilp_parse_core
    import ilp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    input  wire logic [TEXT_W-1:0] byte_data,
    input  wire logic              res_ready,
    output      logic              take,
    output      logic              res_load,
    output      ilp_result_t       res,
    output      ilp_status_t       status
);

    ilp_phase_t         phase_reg;
    ilp_phase_t         phase_next;
    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] radix_next;
    logic               negate_reg;
    logic               negate_next;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;

    logic               term;
    logic [DIGIT_W-1:0] dv;
    logic [RADIX_W-1:0] eff_radix;
    logic [ACC_W-1:0]   acc_scaled;
    logic [ACC_W-1:0]   acc_sum;
    logic [ACC_W-1:0]   acc_out;
    logic               do_digit;

    assign term     = (byte_data == CHAR_NUL);
    assign take     = byte_valid && (!term || res_ready);
    assign res_load = take && term;
    assign dv       = digit_value(byte_data);

    // Radix in force for this byte, including one chosen by this very byte.
    always_comb
    begin
        case (phase_reg)
            PH_START:
            begin
                eff_radix = RADIX_10;
            end
            PH_ZERO:
            begin
                if (byte_data == CHAR_X)
                begin
                    eff_radix = RADIX_16;
                end
                else if (byte_data == CHAR_D)
                begin
                    eff_radix = RADIX_10;
                end
                else if (byte_data == CHAR_B)
                begin
                    eff_radix = RADIX_2;
                end
                else
                begin
                    eff_radix = RADIX_8;
                end
            end
            default:
            begin
                eff_radix = radix_reg;
            end
        endcase
    end

    always_comb
    begin
        case (eff_radix)
            RADIX_2:  acc_scaled = acc_reg << 1;
            RADIX_8:  acc_scaled = acc_reg << 3;
            RADIX_16: acc_scaled = acc_reg << 4;
            default:  acc_scaled = (acc_reg << 3) + (acc_reg << 1);
        endcase
    end

    assign acc_sum = acc_scaled + ACC_W'(dv);

    always_comb
    begin
        phase_next  = phase_reg;
        radix_next  = radix_reg;
        negate_next = negate_reg;
        acc_next    = acc_reg;
        do_digit    = 1'b0;
        if (take)
        begin
            if (term)
            begin
                phase_next  = PH_START;
                radix_next  = RADIX_10;
                negate_next = 1'b0;
                acc_next    = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        if (byte_data == CHAR_ZERO)
                        begin
                            phase_next = PH_ZERO;
                        end
                        else
                        begin
                            radix_next = RADIX_10;
                            phase_next = PH_DIGITS;
                            if (byte_data == CHAR_MINUS)
                            begin
                                negate_next = 1'b1;
                            end
                            else
                            begin
                                do_digit = 1'b1;
                            end
                        end
                    end
                    PH_ZERO:
                    begin
                        phase_next = PH_DIGITS;
                        radix_next = eff_radix;
                        // A second byte that is not a radix letter is the first octal digit.
                        do_digit   = (eff_radix == RADIX_8);
                    end
                    PH_DIGITS:
                    begin
                        do_digit = 1'b1;
                    end
                    default:
                    begin
                        do_digit = 1'b0;
                    end
                endcase

                if (do_digit && (byte_data != CHAR_UNDERSCORE))
                begin
                    if (dv >= DIGIT_W'(eff_radix))
                    begin
                        phase_next = PH_FROZEN;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            radix_reg  <= RADIX_10;
            negate_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            radix_reg  <= radix_next;
            negate_reg <= negate_next;
            acc_reg    <= acc_next;
        end
    end

    assign acc_out        = negate_reg ? (~acc_reg + ACC_W'(1)) : acc_reg;
    assign res.value_low  = acc_out[VALUE_W-1:0];
    assign res.value_high = acc_out[ACC_W-1:VALUE_W];
    assign status.phase   = phase_reg;
    assign status.negate  = negate_reg;

endmodule
`default_nettype wire

// ===== hdl/ilp_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ilp_out_stage
// Result register that holds a parsed value until the sink takes it.
// ----------------------------------------------------------------------------
module ilp_out_stage
    import ilp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire ilp_result_t res,
    output      logic        res_ready,
    ilp_value_if.source      value
);

    logic        valid_reg;
    logic        valid_next;
    ilp_result_t res_reg;

    assign res_ready = !valid_reg || value.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (value.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign value.valid      = valid_reg;
    assign value.value_low  = res_reg.value_low;
    assign value.value_high = res_reg.value_high;

endmodule
`default_nettype wire

// ===== hdl/integer_literal_parser_128.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_literal_parser_128
// Streaming parser of a prefixed integer literal into a 128-bit value.
// Each digit byte goes through a combinational shift-add path.
// Throughput: one text byte per cycle unless a terminator meets a blocked result.
// The result register lets a new byte in while a value waits to be taken.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to the start of a literal in radix ten with a zero value.
// ----------------------------------------------------------------------------
`include "integer_literal_parser_128_macros.svh"

module integer_literal_parser_128
    import ilp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ilp_text_if.sink    text,
    ilp_value_if.source value
);

    logic              byte_valid;
    logic [TEXT_W-1:0] byte_data;
    logic              take;
    logic              res_load;
    logic              res_ready;
    ilp_result_t       res;
    ilp_status_t       status;

    ilp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ilp_parse_core u_parse_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .res_ready  (res_ready),
        .take       (take),
        .res_load   (res_load),
        .res        (res),
        .status     (status)
    );

    ilp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res       (res),
        .res_ready (res_ready),
        .value     (value)
    );

    // A finished literal leaves the parser at the start state without a sign.
    `ILP_ASSERT_NEXT(a_term_resets, res_load, (status.phase == PH_START) && !status.negate)
    // A new result appears only after a terminator was taken.
    `ILP_ASSERT_SAME(a_result_source, $rose(value.valid), $past(res_load))
    // The parser stalls only on a terminator behind a full, blocked result register.
    `ILP_ASSERT_SAME(a_stall_cause, byte_valid && !take,
        (byte_data == CHAR_NUL) && value.valid && !value.ready)
    // An empty input register always takes a transaction.
    `ILP_ASSERT_SAME(a_in_ready, !byte_valid, text.ready)

endmodule
`default_nettype wire

// ===== verif/integer_literal_parser_128_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_literal_parser_128_test
// Streams prefixed integer literals into the parser, one text byte per
// transaction, and checks every 128-bit value that comes out against an
// in-bench model of the parse, or against a typed value from a short table of
// hand-picked literals that comes first. Random literals of every radix, sign
// and length follow, mixed with noise bytes, with random idling on both channels.
// ----------------------------------------------------------------------------
module integer_literal_parser_128_test
    import ilp_pkg::*;
();

    localparam int RANDOM_BYTES   = 2000;
    localparam int MAX_MESSAGES   = 60;
    localparam int DIRECTED_COUNT = 26;

    typedef struct packed {
        logic        given;
        ilp_result_t value;
    } text_note_t;

    typedef struct packed {
        logic [TEXT_W-1:0] ch;
        logic              given;
        ilp_result_t       value;
    } text_row_t;

    // Typed values are filled in only where the literal is trivial to read.
    localparam text_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{CHAR_NUL,        1'b1, 128'd0},
        '{CHAR_ZERO,       1'b0, 128'd0},
        '{CHAR_NUL,        1'b1, 128'd0},
        '{CHAR_MINUS,      1'b0, 128'd0},
        '{"1",             1'b0, 128'd0},
        '{CHAR_NUL,        1'b1, {2{64'hFFFF_FFFF_FFFF_FFFF}}},
        '{CHAR_ZERO,       1'b0, 128'd0},
        '{CHAR_X,          1'b0, 128'd0},
        '{"F",             1'b0, 128'd0},
        '{CHAR_NUL,        1'b1, 128'd15},
        '{CHAR_ZERO,       1'b0, 128'd0},
        '{CHAR_B,          1'b0, 128'd0},
        '{"1",             1'b0, 128'd0},
        '{"z",             1'b0, 128'd0},
        '{CHAR_NUL,        1'b1, 128'd1},
        '{CHAR_ZERO,       1'b0, 128'd0},
        '{"7",             1'b0, 128'd0},
        '{CHAR_MINUS,      1'b0, 128'd0},
        '{CHAR_NUL,        1'b1, 128'd7},
        '{8'hFF,           1'b0, 128'd0},
        '{CHAR_NUL,        1'b1, 128'd0},
        '{CHAR_ZERO,       1'b0, 128'd0},
        '{CHAR_D,          1'b0, 128'd0},
        '{"9",             1'b0, 128'd0},
        '{CHAR_UNDERSCORE, 1'b0, 128'd0},
        '{CHAR_NUL,        1'b0, 128'd0}
    };

    logic clk;
    logic rst_n;

    ilp_text_if  text_ch ();
    ilp_value_if value_ch ();

    integer_literal_parser_128 uut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .value (value_ch)
    );

    // Parser model state.
    ilp_phase_t         lit_phase;
    logic [RADIX_W-1:0] lit_radix;
    logic               lit_negative;
    logic [ACC_W-1:0]   lit_accum;

    ilp_result_t       pending_values [$];
    text_note_t        text_notes [$];
    logic [TEXT_W-1:0] literal_bytes [$];
    int                fail_count;
    int                bytes_sent;
    bit                no_idle;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic void clear_literal();
        lit_phase    = PH_START;
        lit_radix    = RADIX_10;
        lit_negative = 1'b0;
        lit_accum    = '0;
    endfunction

    function automatic int char_digit(input logic [TEXT_W-1:0] ch);
        if (ch >= "0" && ch <= "9")
            return int'(ch) - int'(CHAR_ZERO);
        if (ch >= "A" && ch <= "Z")
            return int'(ch) - int'("A") + 10;
        if (ch >= "a" && ch <= "z")
            return int'(ch) - int'("a") + 10;
        return -1;
    endfunction

    function automatic void accumulate(input logic [TEXT_W-1:0] ch);
        int d;
        if (ch == CHAR_UNDERSCORE)
            return;
        d = char_digit(ch);
        if (d < 0 || d >= int'(lit_radix))
            lit_phase = PH_FROZEN;
        else
            lit_accum = lit_accum * ACC_W'(lit_radix) + ACC_W'(d);
    endfunction

    // Advances the literal by one byte; returns 1 when the byte ends it.
    function automatic bit parse_byte(input logic [TEXT_W-1:0] ch,
                                      output ilp_result_t outcome);
        logic [ACC_W-1:0] total;
        outcome = '0;
        if (ch == CHAR_NUL)
        begin
            total = lit_negative ? -lit_accum : lit_accum;
            outcome.value_high = total[ACC_W-1:VALUE_W];
            outcome.value_low  = total[VALUE_W-1:0];
            clear_literal();
            return 1'b1;
        end
        case (lit_phase)
            PH_START:
            begin
                if (ch == CHAR_ZERO)
                begin
                    lit_phase = PH_ZERO;
                end
                else if (ch == CHAR_MINUS)
                begin
                    lit_negative = 1'b1;
                    lit_radix    = RADIX_10;
                    lit_phase    = PH_DIGITS;
                end
                else
                begin
                    lit_radix = RADIX_10;
                    lit_phase = PH_DIGITS;
                    accumulate(ch);
                end
            end
            PH_ZERO:
            begin
                lit_phase = PH_DIGITS;
                if (ch == CHAR_X)
                    lit_radix = RADIX_16;
                else if (ch == CHAR_D)
                    lit_radix = RADIX_10;
                else if (ch == CHAR_B)
                    lit_radix = RADIX_2;
                else
                begin
                    lit_radix = RADIX_8;
                    accumulate(ch);
                end
            end
            PH_DIGITS:
            begin
                accumulate(ch);
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_cycles();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_text(input logic [TEXT_W-1:0] ch, input logic given,
                             input ilp_result_t value);
        int gap;
        gap = idle_cycles();
        text_notes.push_back('{given, value});
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= ch;
        do
            @(posedge clk);
        while (!text_ch.ready);
        bytes_sent++;
    endtask

    // Builds one random literal, terminator included, into literal_bytes.
    task automatic build_literal();
        int kind;
        int prefix;
        int radix;
        int ndig;
        int d;
        literal_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            repeat ($urandom_range(0, 8))
                literal_bytes.push_back(TEXT_W'($urandom_range(1, 255)));
        end
        else
        begin
            prefix = $urandom_range(0, 5);
            radix  = 10;
            case (prefix)
                1: literal_bytes.push_back(CHAR_MINUS);
                2:
                begin
                    literal_bytes.push_back(CHAR_ZERO);
                    literal_bytes.push_back(CHAR_X);
                    radix = 16;
                end
                3:
                begin
                    literal_bytes.push_back(CHAR_ZERO);
                    literal_bytes.push_back(CHAR_D);
                end
                4:
                begin
                    literal_bytes.push_back(CHAR_ZERO);
                    literal_bytes.push_back(CHAR_B);
                    radix = 2;
                end
                5:
                begin
                    literal_bytes.push_back(CHAR_ZERO);
                    radix = 8;
                end
                default:
                begin
                end
            endcase
            // Long literals can wrap past 128 bits in every radix.
            ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 140)
                                               : $urandom_range(0, 12);
            for (int i = 0; i < ndig; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    literal_bytes.push_back(CHAR_UNDERSCORE);
                d = $urandom_range(0, radix - 1);
                // A bare leading zero would turn a plain decimal into octal.
                if (prefix == 0 && i == 0 && d == 0)
                    d = 1;
                if (d < 10)
                    literal_bytes.push_back(CHAR_ZERO + TEXT_W'(d));
                else if ($urandom_range(0, 1) == 1)
                    literal_bytes.push_back(TEXT_W'("A") + TEXT_W'(d - 10));
                else
                    literal_bytes.push_back(TEXT_W'("a") + TEXT_W'(d - 10));
            end
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 5))
                    literal_bytes.push_back(TEXT_W'($urandom_range(1, 255)));
            end
        end
        literal_bytes.push_back(CHAR_NUL);
    endtask

    always @(posedge clk)
    begin : text_watch
        text_note_t  note;
        ilp_result_t predicted;
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            note = text_notes.pop_front();
            if (parse_byte(text_ch.text_byte, predicted))
                pending_values.push_back(note.given ? note.value : predicted);
        end
    end

    always @(posedge clk)
    begin : value_watch
        ilp_result_t expected;
        if (rst_n && value_ch.valid && value_ch.ready)
        begin
            if (pending_values.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_MESSAGES)
                    $display("%0t: unexpected value, actual high %h low %h", $time,
                             value_ch.value_high, value_ch.value_low);
            end
            else
            begin
                expected = pending_values.pop_front();
                if (value_ch.value_low !== expected.value_low)
                begin
                    fail_count++;
                    if (fail_count <= MAX_MESSAGES)
                        $display("%0t: value_low expected %h actual %h", $time,
                                 expected.value_low, value_ch.value_low);
                end
                if (value_ch.value_high !== expected.value_high)
                begin
                    fail_count++;
                    if (fail_count <= MAX_MESSAGES)
                        $display("%0t: value_high expected %h actual %h", $time,
                                 expected.value_high, value_ch.value_high);
                end
            end
        end
    end

    // Result side: bursts of ready broken by random stalls.
    initial
    begin
        value_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int stall;
            stall = idle_cycles();
            if (stall > 0)
            begin
                value_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            value_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        #20_000_000;
        $display("integer_literal_parser_128 test failed");
        $finish;
    end

    initial
    begin
        fail_count        = 0;
        bytes_sent        = 0;
        no_idle           = 1'b0;
        clear_literal();
        rst_n             = 1'b0;
        text_ch.valid     <= 1'b0;
        text_ch.text_byte <= CHAR_NUL;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
            send_text(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].given, DIRECTED_ROWS[i].value);

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            // Some literals run with no idling on either channel.
            no_idle = ($urandom_range(0, 9) == 0);
            build_literal();
            foreach (literal_bytes[i])
                send_text(literal_bytes[i], 1'b0, '0);
        end
        no_idle = 1'b0;
        text_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (pending_values.size() != 0);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("integer_literal_parser_128 test passed");
        else
            $display("integer_literal_parser_128 test failed");
        $finish;
    end

endmodule
